[rtl/cpa_pkg.sv]
// ----------------------------------------------------------------------------
// cpa_pkg - shared types and constants of the contiguous page allocator
// Status codes, request kinds, flag bit positions and default sizes.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int MAX_PAGES_DEF  = 256;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 9;
  localparam int FLAG_W  = 2;

  localparam logic [COUNT_W-1:0] POOL_PAGES_RST = 9'd256;
  localparam logic [ADDR_W-1:0]  POOL_BASE_RST  = '0;

  // Flag entry layout
  localparam int FLAG_TAKEN_BIT = 0;
  localparam int FLAG_LAST_BIT  = 1;
  localparam logic [FLAG_W-1:0] FLAG_NONE       = 2'b00;
  localparam logic [FLAG_W-1:0] FLAG_TAKEN      = 2'b01;
  localparam logic [FLAG_W-1:0] FLAG_TAKEN_LAST = 2'b11;

  // Opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_POOL_BASE  = 1'b0;
  localparam logic CFG_POOL_PAGES = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_FREE_BAD   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FREE,
    KIND_REJECT
  } kind_t;

  // Request from the front end to the sequencer
  typedef struct packed {
    logic    start;
    kind_t   kind;
    status_t status;
  } cpa_cmd_t;

  // Sequencer status back to the front end
  typedef struct packed {
    logic    idle;
    logic    done;
    status_t status;
  } cpa_rsp_t;

endpackage

[rtl/contiguous_page_allocator_core.sv]
// Throughput: one request at a time; the page-by-page flag table scan sets the rate.
// Reset: synchronous, active low; afterwards a clearing pass over all MAX_PAGES
//   entries wipes the flag table, during which no request is accepted (config writes are).
// ----------------------------------------------------------------------------
// contiguous_page_allocator_core - first-fit contiguous page allocator
// Keeps taken/last flags per page in a RAM, allocates the lowest fitting run
// of free pages and frees blocks by walking to their last page.
// ----------------------------------------------------------------------------
module contiguous_page_allocator_core #(
  parameter int MAX_PAGES  = cpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = cpa_pkg::PAGE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [cpa_pkg::COUNT_W-1:0]   in_page_count,
  input  logic [cpa_pkg::ADDR_W-1:0]    in_free_address,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [cpa_pkg::ADDR_W-1:0]    out_block_address,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [cpa_pkg::ADDR_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int CMP_W = (cpa_pkg::COUNT_W > CNT_W) ? cpa_pkg::COUNT_W : CNT_W;

  // Configuration registers
  logic [cpa_pkg::ADDR_W-1:0]  pool_base_r;
  logic [cpa_pkg::COUNT_W-1:0] pool_pages_r;

  // Effective pool size: the programmed size saturated to the table depth
  logic [CMP_W-1:0] pages_cmp;
  logic [CMP_W-1:0] count_cmp;
  logic [CNT_W-1:0] pool_n;

  logic in_xfer;
  logic alloc_bad;
  logic free_bad;

  cpa_pkg::cpa_cmd_t cmd;
  cpa_pkg::cpa_rsp_t rsp;
  logic [cpa_pkg::ADDR_W-1:0] rsp_addr;
  logic [cpa_pkg::ADDR_W-1:0] cmd_diff;
  logic                       take;

  // Output register
  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [cpa_pkg::ADDR_W-1:0] out_addr_r;

  // Flag table port
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [cpa_pkg::FLAG_W-1:0] ram_wdata;
  logic [IDX_W-1:0]           ram_raddr;
  logic [cpa_pkg::FLAG_W-1:0] ram_rdata;

  // Configuration writes are always taken; software writes only while idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= cpa_pkg::POOL_BASE_RST;
      pool_pages_r <= cpa_pkg::POOL_PAGES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpa_pkg::CFG_POOL_BASE:  pool_base_r  <= cfg_data;
        cpa_pkg::CFG_POOL_PAGES: pool_pages_r <= cfg_data[cpa_pkg::COUNT_W-1:0];
        default: begin
          pool_base_r <= pool_base_r;
        end
      endcase
    end
  end

  assign pages_cmp = (CMP_W'(pool_pages_r) > CMP_W'(MAX_PAGES)) ?
                     CMP_W'(MAX_PAGES) : CMP_W'(pool_pages_r);
  assign pool_n    = pages_cmp[CNT_W-1:0];
  assign count_cmp = CMP_W'(in_page_count);

  // Accept a new request only while the sequencer sits idle; a finished
  // result may still be waiting in the output register.
  assign in_stall = !rsp.idle;
  assign in_xfer  = in_valid && !in_stall;

  // Screen out requests that need no table walk. The pool-end check of a
  // free is done by the locate pass in the sequencer.
  assign alloc_bad = (in_page_count == '0) || (count_cmp > pages_cmp);
  assign free_bad  = (in_free_address == '0) || (in_free_address < pool_base_r) ||
                     (pool_n == '0);
  assign cmd_diff  = in_free_address - pool_base_r;

  always_comb begin
    cmd.start  = in_xfer;
    cmd.kind   = cpa_pkg::KIND_REJECT;
    cmd.status = cpa_pkg::ST_DONE;
    if (in_opcode == cpa_pkg::OP_ALLOC) begin
      if (alloc_bad) begin
        cmd.status = cpa_pkg::ST_ALLOC_FAIL;
      end else begin
        cmd.kind = cpa_pkg::KIND_ALLOC;
      end
    end else begin
      if (free_bad) begin
        cmd.status = cpa_pkg::ST_FREE_BAD;
      end else begin
        cmd.kind = cpa_pkg::KIND_FREE;
      end
    end
  end

  cpa_seq #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_count (count_cmp[CNT_W-1:0]),
    .cmd_diff  (cmd_diff),
    .pool_n    (pool_n),
    .pool_base (pool_base_r),
    .take      (take),
    .rsp       (rsp),
    .rsp_addr  (rsp_addr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  cpa_ram #(
    .WIDTH (cpa_pkg::FLAG_W),
    .DEPTH (MAX_PAGES)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Move the finished result into the output register once it is free or
  // its content is being transferred this cycle.
  assign take = rsp.done && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (take) begin
      out_status_r <= rsp.status;
      out_addr_r   <= rsp_addr;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;

endmodule

[rtl/cpa_ram.sv]
// ----------------------------------------------------------------------------
// cpa_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cpa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/cpa_seq.sv]
// ----------------------------------------------------------------------------
// cpa_seq - page table sequencer
// Clears the flag table, runs the first-fit scan, marks runs, locates and
// walks freed blocks, one page per cycle.
// ----------------------------------------------------------------------------
module cpa_seq #(
  parameter int MAX_PAGES  = cpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = cpa_pkg::PAGE_BYTES_DEF,
  localparam int IDX_W = $clog2(MAX_PAGES),
  localparam int CNT_W = $clog2(MAX_PAGES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cpa_pkg::cpa_cmd_t         cmd,
  input  logic [CNT_W-1:0]          cmd_count,
  input  logic [cpa_pkg::ADDR_W-1:0] cmd_diff,
  input  logic [CNT_W-1:0]          pool_n,
  input  logic [cpa_pkg::ADDR_W-1:0] pool_base,
  input  logic                      take,
  output cpa_pkg::cpa_rsp_t         rsp,
  output logic [cpa_pkg::ADDR_W-1:0] rsp_addr,
  output logic                      ram_we,
  output logic [IDX_W-1:0]          ram_waddr,
  output logic [cpa_pkg::FLAG_W-1:0] ram_wdata,
  output logic [IDX_W-1:0]          ram_raddr,
  input  logic [cpa_pkg::FLAG_W-1:0] ram_rdata
);

  localparam int ACC_W = cpa_pkg::ADDR_W + 1;
  localparam logic [ACC_W-1:0]           PB_ACC  = ACC_W'(PAGE_BYTES);
  localparam logic [cpa_pkg::ADDR_W-1:0] PB_ADDR = cpa_pkg::ADDR_W'(PAGE_BYTES);
  localparam logic [IDX_W-1:0]           IDX_TOP = IDX_W'(MAX_PAGES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOCATE,
    S_SCAN,
    S_WALK,
    S_MARK,
    S_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           idx_r, idx_nxt;
  logic [IDX_W-1:0]           chk_idx_r, chk_idx_nxt;
  logic                       chk_v_r, chk_v_nxt;
  logic [CNT_W-1:0]           run_r, run_nxt;
  logic [IDX_W-1:0]           run_idx_r, run_idx_nxt;
  logic [cpa_pkg::ADDR_W-1:0] run_addr_r, run_addr_nxt;
  logic [cpa_pkg::ADDR_W-1:0] pg_addr_r, pg_addr_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic [IDX_W-1:0]           mk_r, mk_nxt;
  logic [IDX_W-1:0]           last_r, last_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [cpa_pkg::ADDR_W-1:0] diff_r, diff_nxt;
  cpa_pkg::status_t           status_r, status_nxt;
  logic [cpa_pkg::ADDR_W-1:0] addr_r, addr_nxt;

  logic                       rd_ok;
  logic                       chk_end;
  logic [ACC_W-1:0]           acc_sum;
  logic [CNT_W-1:0]           run_inc;
  logic [IDX_W-1:0]           start_idx;
  logic [cpa_pkg::ADDR_W-1:0] start_addr;

  assign rd_ok      = idx_r < pool_n;
  assign chk_end    = (CNT_W'(chk_idx_r) + CNT_W'(1)) == pool_n;
  assign acc_sum    = acc_r + PB_ACC;
  assign run_inc    = run_r + CNT_W'(1);
  assign start_idx  = (run_r == '0) ? chk_idx_r : run_idx_r;
  assign start_addr = (run_r == '0) ? pg_addr_r : run_addr_r;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    chk_idx_nxt  = chk_idx_r;
    chk_v_nxt    = chk_v_r;
    run_nxt      = run_r;
    run_idx_nxt  = run_idx_r;
    run_addr_nxt = run_addr_r;
    pg_addr_nxt  = pg_addr_r;
    acc_nxt      = acc_r;
    mk_nxt       = mk_r;
    last_nxt     = last_r;
    count_nxt    = count_r;
    diff_nxt     = diff_r;
    status_nxt   = status_r;
    addr_nxt     = addr_r;
    ram_we       = 1'b0;
    ram_waddr    = mk_r;
    ram_wdata    = cpa_pkg::FLAG_NONE;
    ram_raddr    = idx_r[IDX_W-1:0];

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (mk_r == IDX_TOP) begin
          state_nxt = S_IDLE;
        end else begin
          mk_nxt = mk_r + IDX_W'(1);
        end
      end

      S_IDLE: begin
        if (cmd.start) begin
          status_nxt  = cmd.status;
          addr_nxt    = '0;
          count_nxt   = cmd_count;
          diff_nxt    = cmd_diff;
          idx_nxt     = '0;
          acc_nxt     = '0;
          chk_v_nxt   = 1'b0;
          run_nxt     = '0;
          pg_addr_nxt = pool_base;
          case (cmd.kind)
            cpa_pkg::KIND_ALLOC: state_nxt = S_SCAN;
            cpa_pkg::KIND_FREE:  state_nxt = S_LOCATE;
            default:             state_nxt = S_DONE;
          endcase
        end
      end

      // Step a byte offset one page at a time until it brackets the address or the pool ends
      S_LOCATE: begin
        if (ACC_W'(diff_r) < acc_sum) begin
          state_nxt = S_WALK;
          chk_v_nxt = 1'b0;
        end else if (idx_r + CNT_W'(1) == pool_n) begin
          status_nxt = cpa_pkg::ST_FREE_BAD;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
          acc_nxt = acc_sum;
        end
      end

      // First-fit search, read of page i+1 overlaps check of page i
      S_SCAN: begin
        chk_v_nxt   = rd_ok;
        chk_idx_nxt = idx_r[IDX_W-1:0];
        if (rd_ok) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (chk_v_r) begin
          pg_addr_nxt = pg_addr_r + PB_ADDR;
          if (ram_rdata[cpa_pkg::FLAG_TAKEN_BIT]) begin
            run_nxt = '0;
            if (chk_end) begin
              status_nxt = cpa_pkg::ST_ALLOC_FAIL;
              state_nxt  = S_DONE;
            end
          end else begin
            run_nxt      = run_inc;
            run_idx_nxt  = start_idx;
            run_addr_nxt = start_addr;
            if (run_inc == count_r) begin
              mk_nxt    = start_idx;
              last_nxt  = chk_idx_r;
              addr_nxt  = start_addr;
              state_nxt = S_MARK;
            end else if (chk_end) begin
              status_nxt = cpa_pkg::ST_ALLOC_FAIL;
              state_nxt  = S_DONE;
            end
          end
        end
      end

      // Clear taken pages until the last-flagged one, an untaken page or the pool end
      S_WALK: begin
        chk_v_nxt   = rd_ok;
        chk_idx_nxt = idx_r[IDX_W-1:0];
        if (rd_ok) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        ram_waddr = chk_idx_r;
        if (chk_v_r) begin
          if (!ram_rdata[cpa_pkg::FLAG_TAKEN_BIT]) begin
            state_nxt = S_DONE;
          end else begin
            ram_we = 1'b1;
            if (ram_rdata[cpa_pkg::FLAG_LAST_BIT] || chk_end) begin
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = (mk_r == last_r) ? cpa_pkg::FLAG_TAKEN_LAST : cpa_pkg::FLAG_TAKEN;
        if (mk_r == last_r) begin
          state_nxt = S_DONE;
        end else begin
          mk_nxt = mk_r + IDX_W'(1);
        end
      end

      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      mk_r    <= '0;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mk_r    <= mk_nxt;
      chk_v_r <= chk_v_nxt;
    end
    idx_r      <= idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    run_r      <= run_nxt;
    run_idx_r  <= run_idx_nxt;
    run_addr_r <= run_addr_nxt;
    pg_addr_r  <= pg_addr_nxt;
    acc_r      <= acc_nxt;
    last_r     <= last_nxt;
    count_r    <= count_nxt;
    diff_r     <= diff_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
  end

  assign rsp.idle   = (state_r == S_IDLE);
  assign rsp.done   = (state_r == S_DONE);
  assign rsp.status = status_r;
  assign rsp_addr   = addr_r;

endmodule

[rtl/cpa_chk.sv]
// ----------------------------------------------------------------------------
// cpa_chk - port-level checker for the page allocator
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module cpa_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 out_status,
  input logic [cpa_pkg::ADDR_W-1:0] out_block_address
);

  // A request occupies the block for at least the following cycle
  a_busy_after_xfer : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted on back-to-back cycles");

  // A held result keeps its payload
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
                              $stable(out_block_address))
    else $error("stalled result changed");

  // Only a successful allocate carries an address
  a_addr_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != cpa_pkg::ST_DONE) |-> out_block_address == '0)
    else $error("failed or free result carries an address");

  // The table clearing pass blocks requests right after reset
  a_clear_stall : assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request path open during table clear");

  // A new result appears only after the block was busy
  a_result_busy : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without preceding work");

endmodule

bind contiguous_page_allocator_core cpa_chk u_cpa_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_block_address (out_block_address)
);
